[rtl/core/flpi_pkg.sv]
// package: types, widths and constants of the flow pi loop with self-calibration
package flpi_pkg;

  localparam int FRAC_BITS      = 8;
  localparam int GAIN_FRAC      = 12;
  localparam int SETTLE_SAMPLES = 10;

  localparam int FLOW_W     = 14;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 20;
  localparam int DUTY_W     = 8;
  localparam int EST_W      = 16;
  localparam int EST_FRAC   = 8;
  localparam int SETTLE_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int ERR_W    = FLOW_W + 1;
  localparam int SUM_W    = 22;
  localparam int PROD_W   = GAIN_W + SUM_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int ACCUM_W  = DUTY_W + FRAC_BITS;
  localparam int PI_SHIFT = GAIN_FRAC - FRAC_BITS;
  localparam int DIV_W    = FLOW_W + EST_FRAC;
  localparam int DCNT_W   = $clog2(DIV_W);

  // blend divide by five as a reciprocal multiply, exact for every blend value
  localparam int BLEND_W     = EST_W + 3;
  localparam int RECIP_W     = 19;
  localparam int RECIP_SHIFT = 21;
  localparam int CAL_PROD_W  = BLEND_W + RECIP_W;
  localparam logic [RECIP_W-1:0] CAL_RECIP = RECIP_W'(419431);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_FLOW  = 3'd0,
    CFG_PROP_GAIN    = 3'd1,
    CFG_INTEG_GAIN   = 3'd2,
    CFG_INTEG_LIMIT  = 3'd3,
    CFG_PWM_FLOOR    = 3'd4,
    CFG_PWM_CEILING  = 3'd5,
    CFG_SETTLE_TOL   = 3'd6,
    CFG_SEED_FPS     = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAND,
    ST_MULI,
    ST_ROUND,
    ST_SUM,
    ST_DUTY,
    ST_DIVF,
    ST_NF,
    ST_EST,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [FLOW_W-1:0] measured_flow;
    logic              run;
    logic              restart;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] pwm_duty;
    logic              at_limit;
    logic              calibrated;
    logic [EST_W-1:0]  flow_per_step;
  } out_t;

endpackage

[rtl/core/flow_pi_loop_with_self_calibration_core.sv]
// top level: sequenced pi flow loop with anti-windup and flow per step calibration
//
// usage:
//   in channel (in_valid_i, in_stall_o, in_data_i) takes one flow sample per
//   transaction; out channel (out_valid_o, out_stall_i, out_data_o) returns
//   exactly one result per sample, in order.
//   the config port writes register cfg_idx_i with cfg_wdata_i whenever cfg_we_i
//   is high; write only while no sample is in flight. a seed write also loads
//   the flow per step estimate.
// timing:
//   one sample at a time. a sample with run low skips the pi update; a pi
//   update steps through the cand, muli, round, sum and duty states, and a
//   calibrating sample then runs a one bit per cycle restoring divider for
//   flow/duty, 22 steps, then divides the blend by five with a reciprocal
//   multiply. pi products share one 16x22 multiplier, proportional then integral.
// reset:
//   config registers take defaults, loop state is cleared; payload is not reset.
// stall:
//   a finished result waits in the output register; the block accepts the next
//   sample meanwhile and holds its following result until the register frees.
module flow_pi_loop_with_self_calibration_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  flpi_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output flpi_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [flpi_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [flpi_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import flpi_pkg::*;

  localparam logic signed [ACC_W-1:0] PI_HALF    = (ACC_W'(1) << PI_SHIFT) >> 1;
  localparam logic signed [ACC_W-1:0] PI_THREE   = ACC_W'(3) << FRAC_BITS;
  localparam logic [ACCUM_W:0]        DUTY_HALF  = (ACCUM_W+1)'(1) << (FRAC_BITS - 1);
  localparam logic [DCNT_W-1:0]       DCNT_LAST  = DCNT_W'(DIV_W - 1);

  // configuration registers
  logic [FLOW_W-1:0]        target_flow_q;
  logic signed [GAIN_W-1:0] prop_gain_q;
  logic signed [GAIN_W-1:0] integ_gain_q;
  logic [LIMIT_W-1:0]       integ_limit_q;
  logic [DUTY_W-1:0]        pwm_floor_q;
  logic [DUTY_W-1:0]        pwm_ceiling_q;
  logic [FLOW_W-1:0]        settle_tol_q;

  // loop state and sequencer datapath
  state_e                   state_q, state_d;
  logic [ACCUM_W-1:0]       accum_q, accum_d;
  logic signed [SUM_W-1:0]  error_sum_q, error_sum_d;
  logic [SETTLE_W-1:0]      settle_q, settle_d;
  logic [DUTY_W-1:0]        duty_now_q, duty_now_d;
  logic [EST_W-1:0]         est_q, est_d;
  logic [FLOW_W-1:0]        flow_q, flow_d;
  logic signed [ERR_W-1:0]  err_q, err_d;
  logic signed [SUM_W-1:0]  cand_q, cand_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     cal_q, cal_d;
  logic [DUTY_W-1:0]        rem_q, rem_d;
  logic [DIV_W-1:0]         quo_q, quo_d;
  logic [DUTY_W-1:0]        dvs_q, dvs_d;
  logic [DCNT_W-1:0]        cnt_q, cnt_d;
  logic                     out_valid_q, out_valid_d;
  out_t                     out_q, out_d;

  // combinational helpers
  logic                     in_acc_w;
  logic                     out_free_w;
  logic                     out_load_w;
  logic                     cal_start_w;
  logic                     div_last_w;
  logic signed [GAIN_W-1:0] mul_a_w;
  logic signed [SUM_W-1:0]  mul_b_w;
  logic signed [PROD_W-1:0] prod_w;
  logic signed [SUM_W:0]    t_w, lim_w;
  logic signed [ACC_W-1:0]  rnd_w, pi_w, nsum_w, lo_s_w, hi_s_w;
  logic [ACCUM_W-1:0]       lo_w, hi_w;
  logic [ACCUM_W:0]         dr_w;
  logic [DUTY_W-1:0]        duty_w, usable_w;
  logic                     lim_hit_w;
  logic [ERR_W-1:0]         mag_w;
  logic                     settled_w;
  logic [SETTLE_W-1:0]      settle_inc_w;
  logic [DUTY_W:0]          rem_sh_w;
  logic                     ge_w;
  logic [EST_W-1:0]         quo_sat_w;
  logic [EST_W+2:0]         blend_w;
  logic [CAL_PROD_W-1:0]    cal_prod_w;

  assign in_acc_w   = in_valid_i && !in_stall_o;
  assign out_free_w = !out_valid_q || !out_stall_i;
  assign div_last_w = (cnt_q == DCNT_LAST);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = in_data_i.run ? ST_CAND : ST_OUT;
      ST_CAND:  state_d = ST_MULI;
      ST_MULI:  state_d = ST_ROUND;
      ST_ROUND: state_d = ST_SUM;
      ST_SUM:   state_d = ST_DUTY;
      ST_DUTY:  state_d = cal_start_w ? ST_DIVF : ST_OUT;
      ST_DIVF:  if (div_last_w) state_d = ST_NF;
      ST_NF:    state_d = ST_EST;
      ST_EST:   state_d = ST_OUT;
      ST_OUT:   if (out_free_w) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    out_load_w = 1'b0;
    mul_a_w    = prop_gain_q;
    mul_b_w    = SUM_W'(err_q);
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_MULI: begin
        mul_a_w = integ_gain_q;
        mul_b_w = cand_q;
      end
      ST_OUT:  out_load_w = out_free_w;
      default: in_stall_o = 1'b1;
    endcase
  end

  // shared multiplier
  assign prod_w = mul_a_w * mul_b_w;

  // integral candidate
  assign t_w   = (SUM_W+1)'(error_sum_q) + (SUM_W+1)'(err_q);
  assign lim_w = signed'((SUM_W+1)'(integ_limit_q));

  // pi rounding and zero flow clamp
  assign rnd_w = acc_q + PI_HALF;
  always_comb begin
    pi_w = rnd_w >>> PI_SHIFT;
    if (flow_q == '0) begin
      if (pi_w > PI_THREE) pi_w = PI_THREE;
      if (pi_w < -PI_THREE) pi_w = -PI_THREE;
    end
  end

  // accumulator clamp
  assign lo_w   = {pwm_floor_q, {FRAC_BITS{1'b0}}};
  assign hi_w   = {pwm_ceiling_q, {FRAC_BITS{1'b0}}};
  assign lo_s_w = signed'(ACC_W'(lo_w));
  assign hi_s_w = signed'(ACC_W'(hi_w));
  assign nsum_w = signed'(ACC_W'(accum_q)) + acc_q;

  // duty and settle decision
  assign dr_w         = {1'b0, accum_q} + DUTY_HALF;
  assign duty_w       = dr_w[FRAC_BITS +: DUTY_W];
  assign lim_hit_w    = (duty_w == pwm_floor_q) || (duty_w == pwm_ceiling_q);
  assign mag_w        = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
  assign settled_w    = (mag_w <= ERR_W'(settle_tol_q)) && !lim_hit_w &&
                        (duty_w > pwm_floor_q);
  assign settle_inc_w = settle_q + SETTLE_W'(1);
  assign cal_start_w  = settled_w && (settle_inc_w >= SETTLE_W'(SETTLE_SAMPLES));
  assign usable_w     = duty_w - pwm_floor_q;

  // restoring divider step
  assign rem_sh_w  = {rem_q, quo_q[DIV_W-1]};
  assign ge_w      = rem_sh_w >= {1'b0, dvs_q};
  assign quo_sat_w = (quo_q[DIV_W-1:EST_W] != '0) ? {EST_W{1'b1}} : quo_q[EST_W-1:0];
  assign blend_w   = {1'b0, est_q, 2'b00} + (EST_W+3)'(quo_sat_w) + (EST_W+3)'(2);

  // blend divided by five
  assign cal_prod_w = CAL_PROD_W'(quo_q[BLEND_W-1:0]) * CAL_PROD_W'(CAL_RECIP);

  always_comb begin
    accum_d     = accum_q;
    error_sum_d = error_sum_q;
    settle_d    = settle_q;
    duty_now_d  = duty_now_q;
    est_d       = est_q;
    flow_d      = flow_q;
    err_d       = err_q;
    cand_d      = cand_q;
    acc_d       = acc_q;
    cal_d       = cal_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dvs_d       = dvs_q;
    cnt_d       = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc_w) begin
          flow_d = in_data_i.measured_flow;
          err_d  = signed'(ERR_W'(target_flow_q)) - signed'(ERR_W'(in_data_i.measured_flow));
          cal_d  = 1'b0;
          if (in_data_i.restart) begin
            error_sum_d = '0;
            accum_d     = lo_w;
            duty_now_d  = pwm_floor_q;
            settle_d    = '0;
          end
        end
      end
      ST_CAND: begin
        if (flow_q == '0) begin
          cand_d = error_sum_q;
        end else if (t_w < -lim_w) begin
          cand_d = SUM_W'(-lim_w);
        end else if (t_w > lim_w) begin
          cand_d = SUM_W'(lim_w);
        end else begin
          cand_d = SUM_W'(t_w);
        end
        acc_d = ACC_W'(prod_w);
      end
      ST_MULI:  acc_d = acc_q + ACC_W'(prod_w);
      ST_ROUND: acc_d = pi_w;
      ST_SUM: begin
        if (nsum_w < lo_s_w) begin
          accum_d = lo_w;
        end else if (nsum_w > hi_s_w) begin
          accum_d = hi_w;
        end else begin
          accum_d = ACCUM_W'(nsum_w);
        end
      end
      ST_DUTY: begin
        duty_now_d = duty_w;
        if (!lim_hit_w) error_sum_d = cand_q;
        if (!settled_w || cal_start_w) begin
          settle_d = '0;
        end else begin
          settle_d = settle_inc_w;
        end
        rem_d = '0;
        quo_d = DIV_W'({flow_q, {EST_FRAC{1'b0}}}) + DIV_W'(usable_w[DUTY_W-1:1]);
        dvs_d = usable_w;
        cnt_d = '0;
      end
      ST_DIVF: begin
        rem_d = ge_w ? DUTY_W'(rem_sh_w - {1'b0, dvs_q}) : DUTY_W'(rem_sh_w);
        quo_d = {quo_q[DIV_W-2:0], ge_w};
        cnt_d = cnt_q + DCNT_W'(1);
      end
      ST_NF: begin
        quo_d = DIV_W'(blend_w);
      end
      ST_EST: begin
        est_d = cal_prod_w[RECIP_SHIFT +: EST_W];
        cal_d = 1'b1;
      end
      default: cal_d = cal_q;
    endcase
    if (cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_SEED_FPS)) begin
      est_d = cfg_wdata_i[EST_W-1:0];
    end
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load_w) begin
      out_valid_d         = 1'b1;
      out_d.pwm_duty      = duty_now_q;
      out_d.at_limit      = (duty_now_q == pwm_floor_q) || (duty_now_q == pwm_ceiling_q);
      out_d.calibrated    = cal_q;
      out_d.flow_per_step = est_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      target_flow_q <= '0;
      prop_gain_q   <= GAIN_W'(2048);
      integ_gain_q  <= GAIN_W'(410);
      integ_limit_q <= LIMIT_W'(1000);
      pwm_floor_q   <= DUTY_W'(30);
      pwm_ceiling_q <= DUTY_W'(255);
      settle_tol_q  <= FLOW_W'(20);
      accum_q       <= '0;
      error_sum_q   <= '0;
      settle_q      <= '0;
      duty_now_q    <= '0;
      est_q         <= '0;
      cal_q         <= 1'b0;
      cnt_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      accum_q     <= accum_d;
      error_sum_q <= error_sum_d;
      settle_q    <= settle_d;
      duty_now_q  <= duty_now_d;
      est_q       <= est_d;
      cal_q       <= cal_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TARGET_FLOW: target_flow_q <= cfg_wdata_i[FLOW_W-1:0];
          CFG_PROP_GAIN:   prop_gain_q   <= cfg_wdata_i[GAIN_W-1:0];
          CFG_INTEG_GAIN:  integ_gain_q  <= cfg_wdata_i[GAIN_W-1:0];
          CFG_INTEG_LIMIT: integ_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
          CFG_PWM_FLOOR:   pwm_floor_q   <= cfg_wdata_i[DUTY_W-1:0];
          CFG_PWM_CEILING: pwm_ceiling_q <= cfg_wdata_i[DUTY_W-1:0];
          CFG_SETTLE_TOL:  settle_tol_q  <= cfg_wdata_i[FLOW_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    flow_q <= flow_d;
    err_q  <= err_d;
    cand_q <= cand_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    out_q  <= out_d;
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a transaction without going busy");

  a_cal_off_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.calibrated |-> !out_data_o.at_limit)
    else $error("calibrated result with duty on a limit");

  a_settle_cleared_on_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIVF |-> settle_q == '0)
    else $error("settle counter not cleared during calibration");

endmodule

[tb/tb_flow_pi_loop_with_self_calibration_core.sv]
// testbench of the flow pi loop core: predicts every sample result and checks it in order

class pi_loop_scoreboard;
  int target, kp, ki, lim, pwm_lo, pwm_hi, tol;
  longint accum;
  int err_sum, settle, duty_now, est;
  flpi_pkg::out_t pending[$];
  int n_checked, n_fail, n_cal, n_cfg;

  function new();
    target = 0;
    kp = 2048;
    ki = 410;
    lim = 1000;
    pwm_lo = 30;
    pwm_hi = 255;
    tol = 20;
    accum = 0;
    err_sum = 0;
    settle = 0;
    duty_now = 0;
    est = 0;
    n_checked = 0;
    n_fail = 0;
    n_cal = 0;
    n_cfg = 0;
  endfunction

  function bit on_limit(int d);
    return d == pwm_lo || d == pwm_hi;
  endfunction

  function void write_reg(flpi_pkg::cfg_idx_e idx, logic [flpi_pkg::CFG_DATA_W-1:0] v);
    case (idx)
      flpi_pkg::CFG_TARGET_FLOW: target = int'(v[13:0]);
      flpi_pkg::CFG_PROP_GAIN:   kp = int'($signed(v[15:0]));
      flpi_pkg::CFG_INTEG_GAIN:  ki = int'($signed(v[15:0]));
      flpi_pkg::CFG_INTEG_LIMIT: lim = int'(v[19:0]);
      flpi_pkg::CFG_PWM_FLOOR:   pwm_lo = int'(v[7:0]);
      flpi_pkg::CFG_PWM_CEILING: pwm_hi = int'(v[7:0]);
      flpi_pkg::CFG_SETTLE_TOL:  tol = int'(v[13:0]);
      flpi_pkg::CFG_SEED_FPS:    est = int'(v[15:0]);
      default: ;
    endcase
    n_cfg++;
  endfunction

  // works out the result of one accepted sample and queues it
  function void note_sample(flpi_pkg::in_t s);
    int flow, err, cand, t, duty, mag, usable, nf, ne;
    longint pi, lo, hi, three;
    bit lim_hit, cal;
    flpi_pkg::out_t r;
    flow = int'(s.measured_flow);
    cal = 1'b0;
    if (s.restart) begin
      err_sum = 0;
      accum = longint'(pwm_lo) << flpi_pkg::FRAC_BITS;
      duty_now = pwm_lo;
      settle = 0;
    end
    if (s.run) begin
      err = target - flow;
      cand = err_sum;
      if (flow > 0) begin
        t = err_sum + err;
        cand = (t < -lim) ? -lim : ((t > lim) ? lim : t);
      end
      pi = longint'(kp) * err + longint'(ki) * cand;
      // round to nearest, ties up, from q.12 down to the accumulator fraction
      pi = (pi + (longint'(1) << (flpi_pkg::PI_SHIFT - 1))) >>> flpi_pkg::PI_SHIFT;
      if (flow == 0) begin
        three = longint'(3) << flpi_pkg::FRAC_BITS;
        if (pi > three) pi = three;
        if (pi < -three) pi = -three;
      end
      accum += pi;
      lo = longint'(pwm_lo) << flpi_pkg::FRAC_BITS;
      hi = longint'(pwm_hi) << flpi_pkg::FRAC_BITS;
      if (accum < lo) accum = lo;
      else if (accum > hi) accum = hi;
      duty = int'((accum + (longint'(1) << (flpi_pkg::FRAC_BITS - 1))) >>> flpi_pkg::FRAC_BITS)
             & 'hFF;
      lim_hit = on_limit(duty);
      if (!lim_hit) err_sum = cand;
      duty_now = duty;
      mag = (err < 0) ? -err : err;
      if (mag <= tol && !lim_hit && duty > pwm_lo) begin
        settle = (settle + 1) & 'hFF;
        if (settle >= flpi_pkg::SETTLE_SAMPLES) begin
          usable = duty - pwm_lo;
          nf = ((flow << flpi_pkg::EST_FRAC) + usable / 2) / usable;
          if (nf > 65535) nf = 65535;
          ne = (4 * est + nf + 2) / 5;
          if (ne > 65535) ne = 65535;
          est = ne;
          cal = 1'b1;
          settle = 0;
          n_cal++;
        end
      end else begin
        settle = 0;
      end
    end
    r.pwm_duty = duty_now[7:0];
    r.at_limit = on_limit(duty_now);
    r.calibrated = cal;
    r.flow_per_step = est[15:0];
    pending.push_back(r);
  endfunction

  function void check_result(flpi_pkg::out_t got);
    flpi_pkg::out_t want;
    if (pending.size() == 0) begin
      $error("result with no sample pending: pwm_duty %0d", got.pwm_duty);
      n_fail++;
      return;
    end
    want = pending.pop_front();
    n_checked++;
    if (got.pwm_duty !== want.pwm_duty) begin
      $error("pwm_duty: expected %0d, actual %0d", want.pwm_duty, got.pwm_duty);
      n_fail++;
    end
    if (got.at_limit !== want.at_limit) begin
      $error("at_limit: expected %0d, actual %0d", want.at_limit, got.at_limit);
      n_fail++;
    end
    if (got.calibrated !== want.calibrated) begin
      $error("calibrated: expected %0d, actual %0d", want.calibrated, got.calibrated);
      n_fail++;
    end
    if (got.flow_per_step !== want.flow_per_step) begin
      $error("flow_per_step: expected %0d, actual %0d", want.flow_per_step, got.flow_per_step);
      n_fail++;
    end
  endfunction
endclass

module tb_flow_pi_loop_with_self_calibration_core;
  import flpi_pkg::*;

  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 64;
  localparam int N_RANDOM     = 1250;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  bit quiet = 1'b0;
  int cycles = 0;
  int n_sent = 0;
  int n_random = 0;
  pi_loop_scoreboard sb = new();

  flow_pi_loop_with_self_calibration_core dut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i = !quiet && ($urandom_range(0, 99) < 15);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  task automatic write_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = v;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_sample(int flow, bit run, bit restart);
    in_t s;
    s.measured_flow = flow[FLOW_W-1:0];
    s.run = run;
    s.restart = restart;
    while (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_sample(s);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic directed_part();
    // reset settings: zero flow clamp, run low, restart with and without run
    send_sample(0, 1'b1, 1'b0);
    send_sample(5, 1'b0, 1'b0);
    send_sample(16383, 1'b0, 1'b1);
    send_sample(16383, 1'b1, 1'b1);
    wait_drained();
    write_register(CFG_TARGET_FLOW, CFG_DATA_W'(16383));
    write_register(CFG_PROP_GAIN, 20'h07FFF);
    write_register(CFG_INTEG_GAIN, 20'h08000);
    write_register(CFG_INTEG_LIMIT, 20'hFFFFF);
    write_register(CFG_PWM_FLOOR, CFG_DATA_W'(0));
    write_register(CFG_PWM_CEILING, CFG_DATA_W'(255));
    write_register(CFG_SETTLE_TOL, CFG_DATA_W'(16383));
    write_register(CFG_SEED_FPS, 20'h0FFFF);
    send_sample(1, 1'b1, 1'b0);
    send_sample(0, 1'b1, 1'b0);
    send_sample(0, 1'b1, 1'b0);
    send_sample(16383, 1'b1, 1'b0);
    wait_drained();
    // floor above ceiling, integral limit dropped to zero
    write_register(CFG_INTEG_LIMIT, CFG_DATA_W'(0));
    write_register(CFG_PWM_FLOOR, CFG_DATA_W'(200));
    write_register(CFG_PWM_CEILING, CFG_DATA_W'(100));
    write_register(CFG_INTEG_GAIN, 20'h00400);
    send_sample(8000, 1'b1, 1'b0);
    send_sample(0, 1'b1, 1'b0);
    send_sample(16383, 1'b1, 1'b0);
    send_sample(12, 1'b1, 1'b1);
    wait_drained();
    // one step above a zero floor, then settled samples up to a calibration whose flow/duty quotient saturates
    write_register(CFG_PROP_GAIN, CFG_DATA_W'(4096));
    write_register(CFG_INTEG_GAIN, CFG_DATA_W'(0));
    write_register(CFG_PWM_FLOOR, CFG_DATA_W'(0));
    write_register(CFG_PWM_CEILING, CFG_DATA_W'(255));
    write_register(CFG_SETTLE_TOL, CFG_DATA_W'(0));
    write_register(CFG_SEED_FPS, CFG_DATA_W'(0));
    send_sample(16382, 1'b1, 1'b1);
    repeat (SETTLE_SAMPLES) send_sample(16383, 1'b1, 1'b0);
    wait_drained();
  endtask

  task automatic random_phase(int n_items, bit loop_phase);
    int slope, flr, eq_off, noise, flow, pick, w;
    logic [CFG_DATA_W-1:0] v;
    bit first_restart;
    slope = $urandom_range(8, 40);
    flr = $urandom_range(0, 40);
    eq_off = $urandom_range(20, 180);
    noise = $urandom_range(0, slope);
    first_restart = $urandom_range(0, 1);
    wait_drained();
    if (loop_phase) begin
      // settings under which a simple linear pump model settles
      write_register(CFG_TARGET_FLOW, CFG_DATA_W'(slope * eq_off));
      write_register(CFG_PROP_GAIN, CFG_DATA_W'(1600 / slope));
      write_register(CFG_INTEG_GAIN, CFG_DATA_W'($urandom_range(0, 2)));
      write_register(CFG_INTEG_LIMIT, CFG_DATA_W'($urandom_range(0, 4000)));
      write_register(CFG_PWM_FLOOR, CFG_DATA_W'(flr));
      write_register(CFG_PWM_CEILING, CFG_DATA_W'($urandom_range(230, 255)));
      write_register(CFG_SETTLE_TOL, CFG_DATA_W'(noise + slope + $urandom_range(0, 20)));
      write_register(CFG_SEED_FPS, CFG_DATA_W'($urandom_range(0, 65535)));
    end else begin
      for (int i = 0; i < 8; i++) begin
        case (cfg_idx_e'(i))
          CFG_TARGET_FLOW, CFG_SETTLE_TOL: w = FLOW_W;
          CFG_PWM_FLOOR, CFG_PWM_CEILING:  w = DUTY_W;
          CFG_INTEG_LIMIT:                 w = LIMIT_W;
          default:                         w = GAIN_W;
        endcase
        pick = $urandom_range(0, 2);
        if (cfg_idx_e'(i) == CFG_PROP_GAIN || cfg_idx_e'(i) == CFG_INTEG_GAIN)
          v = (pick == 0) ? 20'h08000 : (pick == 1) ? 20'h07FFF : 20'($urandom_range(0, 65535));
        else
          v = (pick == 0) ? '0 : (pick == 1) ? 20'((1 << w) - 1) : 20'($urandom & ((1 << w) - 1));
        write_register(cfg_idx_e'(i), v);
      end
    end
    for (int k = 0; k < n_items; k++) begin
      quiet = (n_random >= 500 && n_random < 700);
      if ($urandom_range(0, 149) == 0) wait_drained();
      if (loop_phase && $urandom_range(0, 99) < 80) begin
        flow = slope * (sb.duty_now - flr) + int'($urandom_range(0, 2 * noise)) - noise;
        if (flow < 0) flow = 0;
        if (flow > 16383) flow = 16383;
        send_sample(flow, 1'b1, (k == 0) ? first_restart : ($urandom_range(0, 79) == 0));
      end else begin
        pick = $urandom_range(0, 9);
        flow = (pick == 0) ? 0 : (pick == 1) ? 16383 : int'($urandom_range(0, 16383));
        send_sample(flow, $urandom_range(0, 3) != 0, $urandom_range(0, 9) == 0);
      end
      n_random++;
    end
  endtask

  initial begin
    int phase;
    int phase_len;
    phase = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    directed_part();
    while (n_random < N_RANDOM) begin
      phase_len = $urandom_range(120, 260);
      if (phase_len > N_RANDOM - n_random) phase_len = N_RANDOM - n_random;
      random_phase(phase_len,
                   (phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0));
      phase++;
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("%0d samples sent over %0d setting phases, %0d results checked",
             n_sent, phase, sb.n_checked);
    $display("%0d calibration updates, %0d register writes, %0d mismatches",
             sb.n_cal, sb.n_cfg, sb.n_fail);
    if (sb.n_fail == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
